// ===== rtl/bfcfl_pkg.sv =====
// ----------------------------------------------------------------------------
// bfcfl_pkg
// shared types and codes for the best-fit circular free list unit
// ----------------------------------------------------------------------------
package bfcfl_pkg;

    typedef enum logic [1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_REQUEST = 2'd1,
        FUNC_READ    = 2'd2,
        FUNC_BAD     = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_LOADED = 3'd0,
        ST_SPLIT  = 3'd1,
        ST_EXACT  = 3'd2,
        ST_NOFIT  = 3'd3,
        ST_ENTRY  = 3'd4,
        ST_ERROR  = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD_RD,
        S_LOAD_WR,
        S_LOAD_LNK,
        S_REQ_RD,
        S_REQ_CMP,
        S_REQ_LNK,
        S_REQ_WR,
        S_READ_RD,
        S_READ_OUT,
        S_RESULT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;      // latch input beat
        logic load_tail;    // read prev link table at cursor
        logic load_write;   // write new slot with its own links
        logic load_link;    // point old tail and cursor at the new slot
        logic walk_start;   // start the ring walk at cursor
        logic walk_issue;   // issue table read at walk pointer
        logic walk_cmp;     // compare returned entry and advance
        logic fit_link;     // read neighbour links of best slot
        logic fit_write;    // update length, unlink best slot if emptied
        logic read_issue;   // issue table read for read beat
        logic read_out;     // form read result
        logic err_out;      // form error or no-fit result
        logic [2:0] err_code;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [1:0] func;
        logic       full;
        logic       empty;
        logic       walk_done;
        logic       found;
    } stat_t;

endpackage

// ===== rtl/best_fit_circular_free_list_unit.sv =====
// ----------------------------------------------------------------------------
// best_fit_circular_free_list_unit
// best-fit allocator over a circular doubly linked free list in on-chip rams
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  input   | in        | in_valid / in_stall     | func, block_start, size_value
//  output  | out       | out_valid / out_stall   | status, entry_start, entry_length,
//          |           |                         | entry_index, last
//
// one beat at a time: load reads the tail link, writes the new slot and links it;
// request walks every live block, then updates the best fit; read fetches one entry;
// unknown func, full table or empty list go straight to the result (one ram read and compare per ring step)
// the next input beat can be taken in the cycle after the result is loaded
// reset clears cursor, counters, walk and result registers; tables are never cleared
// output register holds the result while out_stall is high; a new beat may be
// taken meanwhile, and its result waits until the output register is free
module best_fit_circular_free_list_unit
    import bfcfl_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024,
    parameter int ADDR_BITS  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [31:0] block_start,
    input  logic [31:0] size_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] entry_start,
    output logic [31:0] entry_length,
    output logic [9:0]  entry_index,
    output logic        last
);

    cmd_t  cmd;
    stat_t stat;
    logic  out_load;
    logic  valid_reg;
    logic [2:0]  rs;
    logic [31:0] rstart, rlen;
    logic [9:0]  ridx;
    logic        rlast;

    bfcfl_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_busy(valid_reg), .out_load(out_load), .stat(stat), .cmd(cmd));

    bfcfl_dp #(.MAX_BLOCKS(MAX_BLOCKS), .ADDR_BITS(ADDR_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .func(func), .block_start(block_start),
        .size_value(size_value), .cmd(cmd), .stat(stat), .res_status(rs),
        .res_start(rstart), .res_length(rlen), .res_index(ridx), .res_last(rlast));

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status       <= rs;
            entry_start  <= rstart;
            entry_length <= rlen;
            entry_index  <= ridx;
            last         <= rlast;
        end
    end

    assign out_valid = valid_reg;

endmodule

// ===== rtl/bfcfl_ram.sv =====
// ----------------------------------------------------------------------------
// bfcfl_ram
// single port write, single port read ram with registered read data
// ----------------------------------------------------------------------------
module bfcfl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/bfcfl_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfcfl_ctrl
// sequencer for load, request walk and read operations
// ----------------------------------------------------------------------------
module bfcfl_ctrl
    import bfcfl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  logic  out_busy,
    output logic  out_load,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        out_load   = 1'b0;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_RESULT;
                    case (stat.func)
                        FUNC_LOAD:    state_next = S_LOAD_RD;
                        FUNC_REQUEST: state_next = S_REQ_RD;
                        FUNC_READ:    state_next = S_READ_RD;
                        default:      state_next = S_RESULT;
                    endcase
                end
            end
            S_LOAD_RD:
            begin
                if (stat.full)
                begin
                    cmd.err_out  = 1'b1;
                    cmd.err_code = ST_ERROR;
                    state_next   = S_RESULT;
                end
                else
                begin
                    cmd.load_tail = 1'b1;
                    state_next    = S_LOAD_WR;
                end
            end
            S_LOAD_WR:
            begin
                cmd.load_write = 1'b1;
                state_next     = S_LOAD_LNK;
            end
            S_LOAD_LNK:
            begin
                cmd.load_link = 1'b1;
                state_next    = S_RESULT;
            end
            S_REQ_RD:
            begin
                if (stat.empty)
                begin
                    cmd.err_out  = 1'b1;
                    cmd.err_code = ST_NOFIT;
                    state_next   = S_RESULT;
                end
                else
                begin
                    cmd.walk_start = 1'b1;
                    state_next     = S_REQ_CMP;
                end
            end
            S_REQ_CMP:
            begin
                cmd.walk_cmp = 1'b1;
                if (stat.walk_done)
                begin
                    state_next = S_REQ_LNK;
                end
                else
                begin
                    cmd.walk_issue = 1'b1;
                    state_next = S_REQ_CMP;
                end
            end
            S_REQ_LNK:
            begin
                if (!stat.found)
                begin
                    cmd.err_out  = 1'b1;
                    cmd.err_code = ST_NOFIT;
                    state_next   = S_RESULT;
                end
                else
                begin
                    cmd.fit_link = 1'b1;
                    state_next   = S_REQ_WR;
                end
            end
            S_REQ_WR:
            begin
                cmd.fit_write = 1'b1;
                state_next    = S_RESULT;
            end
            S_READ_RD:
            begin
                if (stat.empty)
                begin
                    cmd.err_out  = 1'b1;
                    cmd.err_code = ST_ERROR;
                    state_next   = S_RESULT;
                end
                else
                begin
                    cmd.read_issue = 1'b1;
                    state_next     = S_READ_OUT;
                end
            end
            S_READ_OUT:
            begin
                cmd.read_out = 1'b1;
                state_next   = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_busy)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/bfcfl_dp.sv =====
// ----------------------------------------------------------------------------
// bfcfl_dp
// link tables, cursor and walk registers, result formation
// ----------------------------------------------------------------------------
module bfcfl_dp
    import bfcfl_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024,
    parameter int ADDR_BITS  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  func,
    input  logic [31:0] block_start,
    input  logic [31:0] size_value,
    input  cmd_t        cmd,
    output stat_t       stat,
    output logic [2:0]  res_status,
    output logic [31:0] res_start,
    output logic [31:0] res_length,
    output logic [9:0]  res_index,
    output logic        res_last
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = IW + 1;
    localparam int SW = (ADDR_BITS < 32) ? ADDR_BITS : 32;

    // ram ports
    logic          st_we, len_we, nx_we, pv_we;
    logic [IW-1:0] st_wa, len_wa, nx_wa, pv_wa;
    logic [IW-1:0] st_ra, len_ra, nx_ra, pv_ra;
    logic [SW-1:0] st_wd, st_rd;
    logic [31:0]   len_wd, len_rd;
    logic [IW-1:0] nx_wd, nx_rd, pv_wd, pv_rd;

    bfcfl_ram #(.WIDTH(SW), .DEPTH(MAX_BLOCKS)) u_start (
        .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd));
    bfcfl_ram #(.WIDTH(32), .DEPTH(MAX_BLOCKS)) u_len (
        .clk(clk), .we(len_we), .waddr(len_wa), .wdata(len_wd), .raddr(len_ra),
        .rdata(len_rd));
    bfcfl_ram #(.WIDTH(IW), .DEPTH(MAX_BLOCKS)) u_next (
        .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
    bfcfl_ram #(.WIDTH(IW), .DEPTH(MAX_BLOCKS)) u_prev (
        .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd));

    logic [1:0]    func_reg;
    logic [31:0]   bs_reg, sz_reg;
    logic [IW-1:0] cursor_reg, cursor_next;
    logic [CW-1:0] live_reg, live_next, loaded_reg, loaded_next;
    logic [IW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] rdone_reg, rdone_next;
    logic [IW-1:0] walk_reg, walk_next;
    logic [CW-1:0] wcnt_reg, wcnt_next;
    logic [IW-1:0] best_reg, best_next;
    logic [31:0]   blen_reg, blen_next;
    logic          found_reg, found_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [IW-1:0] slot_k;
    logic [31:0]   new_len;

    logic [2:0]    rs_reg, rs_next;
    logic [31:0]   rst_reg, rst_next, rl_reg, rl_next;
    logic [IW-1:0] ri_reg, ri_next;
    logic          rlast_reg, rlast_next;

    assign slot_k  = loaded_reg[IW-1:0];
    assign new_len = blen_reg - sz_reg;

    assign stat.func      = cmd.capture ? func : func_reg;
    assign stat.full      = (loaded_reg == CW'(MAX_BLOCKS));
    assign stat.empty     = (live_reg == '0);
    assign stat.walk_done = (wcnt_reg + CW'(1) >= live_reg);
    assign stat.found     = found_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            bs_reg   <= block_start;
            sz_reg   <= size_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            live_reg   <= '0;
            loaded_reg <= '0;
            rptr_reg   <= '0;
            rdone_reg  <= '0;
            walk_reg   <= '0;
            wcnt_reg   <= '0;
            best_reg   <= '0;
            blen_reg   <= '0;
            found_reg  <= 1'b0;
            tail_reg   <= '0;
            rs_reg     <= '0;
            rst_reg    <= '0;
            rl_reg     <= '0;
            ri_reg     <= '0;
            rlast_reg  <= 1'b0;
        end
        else
        begin
            cursor_reg <= cursor_next;
            live_reg   <= live_next;
            loaded_reg <= loaded_next;
            rptr_reg   <= rptr_next;
            rdone_reg  <= rdone_next;
            walk_reg   <= walk_next;
            wcnt_reg   <= wcnt_next;
            best_reg   <= best_next;
            blen_reg   <= blen_next;
            found_reg  <= found_next;
            tail_reg   <= tail_next;
            rs_reg     <= rs_next;
            rst_reg    <= rst_next;
            rl_reg     <= rl_next;
            ri_reg     <= ri_next;
            rlast_reg  <= rlast_next;
        end
    end

    always_comb
    begin
        cursor_next = cursor_reg;
        live_next   = live_reg;
        loaded_next = loaded_reg;
        rptr_next   = rptr_reg;
        rdone_next  = rdone_reg;
        walk_next   = walk_reg;
        wcnt_next   = wcnt_reg;
        best_next   = best_reg;
        blen_next   = blen_reg;
        found_next  = found_reg;
        tail_next   = tail_reg;
        rs_next     = rs_reg;
        rst_next    = rst_reg;
        rl_next     = rl_reg;
        ri_next     = ri_reg;
        rlast_next  = rlast_reg;
        st_we = 1'b0; len_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0;
        st_wa = slot_k; len_wa = slot_k; nx_wa = slot_k; pv_wa = slot_k;
        st_wd = bs_reg[SW-1:0];
        len_wd = sz_reg;
        nx_wd = cursor_reg;
        pv_wd = cursor_reg;
        st_ra = walk_reg; len_ra = walk_reg; nx_ra = walk_reg; pv_ra = cursor_reg;

        // any beat other than a read restarts the read sequence
        if (cmd.capture && func != FUNC_READ)
        begin
            rdone_next = '0;
        end
        if (cmd.load_tail)
        begin
            pv_ra = cursor_reg;
        end
        if (cmd.load_write)
        begin
            // new slot with its own links, tail kept for the splice
            st_we = 1'b1;
            len_we = 1'b1;
            nx_we = 1'b1;
            pv_we = 1'b1;
            tail_next = pv_rd;
            if (live_reg == '0)
            begin
                nx_wd = slot_k;
                pv_wd = slot_k;
            end
            else
            begin
                pv_wd = pv_rd;
            end
        end
        if (cmd.load_link)
        begin
            // old tail and cursor point at the new slot
            if (live_reg == '0)
            begin
                cursor_next = slot_k;
            end
            else
            begin
                nx_we = 1'b1; nx_wa = tail_reg;   nx_wd = slot_k;
                pv_we = 1'b1; pv_wa = cursor_reg; pv_wd = slot_k;
            end
            rs_next = ST_LOADED;
            rst_next = 32'(bs_reg[SW-1:0]);
            rl_next = sz_reg;
            ri_next = slot_k;
            rlast_next = 1'b0;
            loaded_next = loaded_reg + CW'(1);
            live_next = live_reg + CW'(1);
        end
        if (cmd.walk_start)
        begin
            walk_next  = cursor_reg;
            wcnt_next  = '0;
            found_next = 1'b0;
            st_ra = cursor_reg; len_ra = cursor_reg; nx_ra = cursor_reg;
        end
        if (cmd.walk_cmp)
        begin
            if (len_rd >= sz_reg && (!found_reg || len_rd < blen_reg))
            begin
                best_next  = walk_reg;
                blen_next  = len_rd;
                found_next = 1'b1;
            end
            walk_next = nx_rd;
            wcnt_next = wcnt_reg + CW'(1);
        end
        if (cmd.walk_issue)
        begin
            st_ra = nx_rd; len_ra = nx_rd; nx_ra = nx_rd;
        end
        if (cmd.fit_link)
        begin
            nx_ra = best_reg;
            pv_ra = best_reg;
            st_ra = best_reg;
        end
        if (cmd.fit_write)
        begin
            len_we = 1'b1;
            len_wa = best_reg;
            len_wd = new_len;
            rst_next = 32'(st_rd);
            ri_next = best_reg;
            rlast_next = 1'b0;
            if (new_len == '0)
            begin
                nx_we = 1'b1; nx_wa = pv_rd; nx_wd = nx_rd;
                pv_we = 1'b1; pv_wa = nx_rd; pv_wd = pv_rd;
                cursor_next = nx_rd;
                live_next = live_reg - CW'(1);
                rs_next = ST_EXACT;
                rl_next = '0;
            end
            else
            begin
                cursor_next = best_reg;
                rs_next = ST_SPLIT;
                rl_next = new_len;
            end
        end
        if (cmd.read_issue)
        begin
            if (rdone_reg == '0)
            begin
                st_ra = cursor_reg; len_ra = cursor_reg; nx_ra = cursor_reg;
                rptr_next = cursor_reg;
            end
            else
            begin
                st_ra = rptr_reg; len_ra = rptr_reg; nx_ra = rptr_reg;
            end
        end
        if (cmd.read_out)
        begin
            rs_next = ST_ENTRY;
            rst_next = 32'(st_rd);
            rl_next = len_rd;
            ri_next = rptr_reg;
            if (rdone_reg + CW'(1) >= live_reg)
            begin
                rlast_next = 1'b1;
                rdone_next = '0;
            end
            else
            begin
                rlast_next = 1'b0;
                rdone_next = rdone_reg + CW'(1);
                rptr_next = nx_rd;
            end
        end
        if (cmd.err_out)
        begin
            rs_next = cmd.err_code;
            rst_next = '0; rl_next = '0; ri_next = '0; rlast_next = 1'b0;
            if (func_reg == FUNC_READ)
            begin
                rdone_next = '0;
            end
        end
        if (cmd.capture && func == FUNC_BAD)
        begin
            rs_next = ST_ERROR;
            rst_next = '0; rl_next = '0; ri_next = '0; rlast_next = 1'b0;
        end
    end

    assign res_status = rs_reg;
    assign res_start  = rst_reg;
    assign res_length = rl_reg;
    assign res_index  = 10'(ri_reg);
    assign res_last   = rlast_reg;

endmodule

// ===== rtl/bfcfl_checker.sv =====
// ----------------------------------------------------------------------------
// bfcfl_checker
// port level checks on the free list unit
// ----------------------------------------------------------------------------
module bfcfl_checker
    import bfcfl_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] status,
    input logic       last
);

    // held result stays
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status))
        else $error("result dropped under stall");

    // last only on read entries
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> status == ST_ENTRY)
        else $error("last on non-entry");

    // no beat accepted in the cycle after another
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("overlapping beats");

    // status codes in range
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_ERROR)
        else $error("bad status");

endmodule

bind best_fit_circular_free_list_unit bfcfl_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .last(last));

// ===== tb/tb_best_fit_circular_free_list_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_best_fit_circular_free_list_unit
// drives load, request and read beats into the best-fit free list unit, keeps
// its own copy of the ring and checks every result beat field by field
// ----------------------------------------------------------------------------

// ring model and queue of expected result beats
class free_ring_board;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] start;
        logic [31:0] length;
        logic [9:0]  index;
        logic        last;
    } beat_t;

    localparam int SLOTS = 1024;

    logic [31:0] start_tab [SLOTS];
    logic [31:0] len_tab [SLOTS];
    int          nxt [SLOTS];
    int          prv [SLOTS];
    int          cursor;
    int          live;
    int          loaded;
    int          rd_ptr;
    int          rd_done;
    beat_t       pending [$];
    int          errors;

    function new();
        cursor  = 0;
        live    = 0;
        loaded  = 0;
        rd_ptr  = 0;
        rd_done = 0;
        errors  = 0;
    endfunction

    function void push(logic [2:0] st, logic [31:0] s, logic [31:0] l, int ix,
                       logic lst);
        beat_t b;
        b.status = st;
        b.start  = s;
        b.length = l;
        b.index  = ix[9:0];
        b.last   = lst;
        pending.push_back(b);
    endfunction

    // note one accepted input beat and predict its result
    function void note_input(logic [1:0] fn, logic [31:0] s, logic [31:0] v);
        int x;
        int best;
        int tail;
        int p;
        int n;
        bit found;
        if (fn == bfcfl_pkg::FUNC_READ) begin
            if (live == 0) begin
                rd_done = 0;
                push(bfcfl_pkg::ST_ERROR, 0, 0, 0, 0);
                return;
            end
            if (rd_done == 0)
                rd_ptr = cursor;
            x = rd_ptr;
            rd_done++;
            if (rd_done >= live) begin
                rd_done = 0;
                push(bfcfl_pkg::ST_ENTRY, start_tab[x], len_tab[x], x, 1);
            end
            else begin
                rd_ptr = nxt[x];
                push(bfcfl_pkg::ST_ENTRY, start_tab[x], len_tab[x], x, 0);
            end
            return;
        end
        rd_done = 0;
        if (fn == bfcfl_pkg::FUNC_LOAD) begin
            if (loaded >= SLOTS) begin
                push(bfcfl_pkg::ST_ERROR, 0, 0, 0, 0);
                return;
            end
            x = loaded;
            start_tab[x] = s;
            len_tab[x]   = v;
            if (live == 0) begin
                nxt[x] = x;
                prv[x] = x;
                cursor = x;
            end
            else begin
                tail = prv[cursor];
                nxt[tail] = x;
                prv[x] = tail;
                nxt[x] = cursor;
                prv[cursor] = x;
            end
            loaded++;
            live++;
            push(bfcfl_pkg::ST_LOADED, s, v, x, 0);
        end
        else if (fn == bfcfl_pkg::FUNC_REQUEST) begin
            found = 0;
            best  = 0;
            x     = cursor;
            for (int i = 0; i < live; i++) begin
                if (len_tab[x] >= v && (!found || len_tab[x] < len_tab[best])) begin
                    best  = x;
                    found = 1;
                end
                x = nxt[x];
            end
            if (!found) begin
                push(bfcfl_pkg::ST_NOFIT, 0, 0, 0, 0);
                return;
            end
            len_tab[best] = len_tab[best] - v;
            if (len_tab[best] == 0) begin
                p = prv[best];
                n = nxt[best];
                nxt[p] = n;
                prv[n] = p;
                cursor = n;
                live--;
                push(bfcfl_pkg::ST_EXACT, start_tab[best], 0, best, 0);
            end
            else begin
                cursor = best;
                push(bfcfl_pkg::ST_SPLIT, start_tab[best], len_tab[best], best, 0);
            end
        end
        else begin
            push(bfcfl_pkg::ST_ERROR, 0, 0, 0, 0);
        end
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("error: %s got %0h expected %0h at %0t", what, got, want, $realtime);
    endfunction

    // compare one result beat with the oldest prediction
    function void check_result(logic [2:0] st, logic [31:0] s, logic [31:0] l,
                               logic [9:0] ix, logic lst);
        beat_t e;
        if (pending.size() == 0) begin
            report("unexpected result, status", 32'(st), 32'd0);
            return;
        end
        e = pending.pop_front();
        if (st !== e.status)
            report("status", 32'(st), 32'(e.status));
        if (s !== e.start)
            report("entry_start", s, e.start);
        if (l !== e.length)
            report("entry_length", l, e.length);
        if (ix !== e.index)
            report("entry_index", 32'(ix), 32'(e.index));
        if (lst !== e.last)
            report("last", 32'(lst), 32'(e.last));
    endfunction

endclass

module tb_best_fit_circular_free_list_unit;
    import bfcfl_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  func;
    logic [31:0] block_start;
    logic [31:0] size_value;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [31:0] entry_start;
    logic [31:0] entry_length;
    logic [9:0]  entry_index;
    logic        last;

    free_ring_board board;
    longint        cycles = 0;
    bit            hold_off;     // long receiver hold-off in progress
    bit            stim_done;
    int            beats_sent;   // input beats accepted so far

    best_fit_circular_free_list_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .block_start  (block_start),
        .size_value   (size_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .entry_start  (entry_start),
        .entry_length (entry_length),
        .entry_index  (entry_index),
        .last         (last)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // watchdog: worst request walks every live slot, plus stalls
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 64'd6000000) begin
            $display("best_fit_circular_free_list_unit: mismatch");
            $finish;
        end
    end

    // random gap length: mostly short, now and then long
    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    // random 32-bit word biased towards small values and the extremes
    function automatic logic [31:0] pick_word(int span);
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'hffff_ffff;
            2: return $urandom();
            default: return $urandom_range(0, span);
        endcase
    endfunction

    // offer one beat and wait until it is taken
    task automatic send_beat(logic [1:0] fn, logic [31:0] s, logic [31:0] v);
        func        <= fn;
        block_start <= s;
        size_value  <= v;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        board.note_input(fn, s, v);
        @(negedge clk);
    endtask

    // beat followed by a random gap on the input side
    task automatic send_gapped(logic [1:0] fn, logic [31:0] s, logic [31:0] v);
        int g;
        send_beat(fn, s, v);
        beats_sent++;
        g = stim_done ? 0 : gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    task automatic read_ring();
        int n;
        n = board.live;
        for (int i = 0; i < n && i < 12; i++)
            send_gapped(FUNC_READ, $urandom(), $urandom());
    endtask

    // result side: sample at the rising edge, stall at random
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(status, entry_start, entry_length, entry_index, last);
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off)
            out_stall <= 1'b1;
        else if ($urandom_range(0, 29) == 0)
            out_stall <= 1'b1;
        else if ($urandom_range(0, 3) == 0)
            out_stall <= ($urandom_range(0, 2) == 0);
        else
            out_stall <= 1'b0;
    end

    // long receiver hold-off in its own process, counted in cycles
    initial
    begin
        hold_off = 1'b0;
        wait (beats_sent > 100);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        int kind;
        int waited;
        board       = new();
        stim_done   = 0;
        beats_sent  = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        func        = FUNC_LOAD;
        block_start = '0;
        size_value  = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty list cases, then extremes and each special case
        send_gapped(FUNC_REQUEST, 32'h0, 32'h5);
        send_gapped(FUNC_READ, 32'h0, 32'h0);
        send_gapped(FUNC_BAD, 32'hffff_ffff, 32'hffff_ffff);
        send_gapped(FUNC_LOAD, 32'hffff_ffff, 32'hffff_ffff);
        send_gapped(FUNC_LOAD, 32'h0, 32'h0);
        send_gapped(FUNC_LOAD, 32'h1000, 32'd64);
        send_gapped(FUNC_LOAD, 32'h2000, 32'd64);
        send_gapped(FUNC_LOAD, 32'h3000, 32'd16);
        send_gapped(FUNC_READ, 32'h0, 32'h0);
        send_gapped(FUNC_READ, 32'h0, 32'h0);
        send_gapped(FUNC_BAD, 32'h0, 32'h0);          // read restarts at cursor
        read_ring();
        read_ring();
        send_gapped(FUNC_REQUEST, 32'h0, 32'd0);      // zero size removes zero block
        send_gapped(FUNC_REQUEST, 32'h0, 32'd0);      // zero size, block kept as cursor
        send_gapped(FUNC_REQUEST, 32'h0, 32'd40);     // tie, first met splits
        send_gapped(FUNC_REQUEST, 32'h0, 32'd24);     // exact fit removal
        send_gapped(FUNC_REQUEST, 32'h0, 32'hffff_fffe); // splits the full-length block, leaving 1
        send_gapped(FUNC_REQUEST, 32'h0, 32'hffff_ffff); // no fit
        read_ring();

        // random: loads with random content, requests sized small or extreme
        while (beats_sent < 568) begin
            kind = $urandom_range(0, 99);
            if (kind < 35 && beats_sent < 400)
                send_gapped(FUNC_LOAD, pick_word(32'hffff), pick_word(200));
            else if (kind < 70)
                send_gapped(FUNC_REQUEST, $urandom(), pick_word(200));
            else if (kind < 90)
                send_gapped(FUNC_READ, $urandom(), $urandom());
            else if (kind < 93)
                send_gapped(FUNC_BAD, $urandom(), $urandom());
            else if (kind < 97)
                read_ring();
            else
                send_gapped(FUNC_LOAD, $urandom(), $urandom());
        end

        read_ring();
        send_gapped(FUNC_REQUEST, 32'h0, 32'd7);
        stim_done = 1;
        in_valid <= 1'b0;

        // drain
        waited = 0;
        while (board.pending.size() != 0 && waited < 200000) begin
            @(negedge clk);
            waited++;
        end
        repeat (50) @(negedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("best_fit_circular_free_list_unit: match");
        else
            $display("best_fit_circular_free_list_unit: mismatch");
        $finish;
    end

endmodule
